// ===== sv/gntf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gntf_pkg: shared types for the gated nearest track heading fix unit
// Request, result and stored track records.
// ----------------------------------------------------------------------------
package gntf_pkg;

    localparam logic [1:0] FUNC_BOX   = 2'd0;
    localparam logic [1:0] FUNC_SWAP  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [31:0] GATE_RESET = 32'd41943;

    typedef struct packed {
        logic        [1:0]  func;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] heading_x;
        logic signed [15:0] heading_y;
    } t_req;

    typedef struct packed {
        logic               matched;
        logic        [5:0]  match_index;
        logic               flipped;
        logic signed [15:0] out_heading_x;
        logic signed [15:0] out_heading_y;
        logic               overflow;
    } t_res;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] hx;
        logic signed [15:0] hy;
    } t_track;

endpackage

// ===== sv/gntf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gntf_cell: one slot of the track chain
// Holds one previous-frame track, which rotates along the chain, and one
// current-frame track, which is copied over on a frame swap.
// ----------------------------------------------------------------------------
module gntf_cell (
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic              i_copy,
    input  logic              i_wr,
    input  gntf_pkg::t_track  i_shin,
    input  gntf_pkg::t_track  i_wdata,
    output gntf_pkg::t_track  o_prev
);
    import gntf_pkg::*;

    t_track r_prev;
    t_track r_cur;

    always_ff @(posedge i_clk) begin
        if (i_copy) begin
            r_prev <= r_cur;
        end else if (i_shift) begin
            r_prev <= i_shin;
        end
        if (i_wr) begin
            r_cur <= i_wdata;
        end
    end

    assign o_prev = r_prev;

endmodule

// ===== sv/gated_nearest_track_heading_fix_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_nearest_track_heading_fix_unit: gated nearest track heading fix
// Matches a box against the previous frame's tracks and corrects its heading.
// ----------------------------------------------------------------------------
// Sequence: a box request rotates the whole track chain past the distance
// unit, then steps through the last, multiply and finish states to its
// result strobe; swap, clear and unused requests complete on acceptance with
// no result. Requests wait while busy. The receiver cannot stall results.
// Reset: synchronous, active low; clears both list counts, the gate register
// to its default and the controller. Track contents are not cleared.
// ----------------------------------------------------------------------------
module gated_nearest_track_heading_fix_unit #(
    parameter int MAX_TRACKS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  gntf_pkg::t_req i_req,
    output logic           o_strobe,
    output gntf_pkg::t_res o_res,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_wdata
);
    import gntf_pkg::*;

    // Count width holds 0..MAX_TRACKS; index width holds 0..MAX_TRACKS-1.
    localparam int CW = $clog2(MAX_TRACKS + 1);
    localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_LAST = 5'b00100,
        S_MUL  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        return (v == 16'sh8000) ? 16'sh7fff : -v;
    endfunction

    t_state           r_state;
    logic [31:0]      r_gate;
    logic [CW-1:0]    r_prev_cnt;
    logic [CW-1:0]    r_cur_cnt;
    logic [CW-1:0]    r_j;
    t_req             r_req;

    // Distance pipeline: stage A squares, stage B adds and compares.
    logic             r_a_v;
    logic [IW-1:0]    r_a_idx;
    logic [31:0]      r_sqx;
    logic [31:0]      r_sqy;
    logic signed [15:0] r_a_hx;
    logic signed [15:0] r_a_hy;

    logic             r_matched;
    logic [IW-1:0]    r_best;
    logic [32:0]      r_best_d2;
    logic signed [15:0] r_bhx;
    logic signed [15:0] r_bhy;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;

    logic             r_strobe;
    t_res             r_res;

    t_track           w_prev [MAX_TRACKS];
    t_track           w_wdata;
    logic             w_shift;
    logic             w_copy;
    logic             w_append;
    logic             w_accept;

    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic signed [33:0] w_sqx;
    logic signed [33:0] w_sqy;
    logic [32:0]        w_d2;
    logic signed [32:0] w_dot;
    logic               w_flip;
    logic signed [15:0] w_hx;
    logic signed [15:0] w_hy;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_shift  = (r_state == S_SCAN);
    assign w_copy   = w_accept && (i_req.func == FUNC_SWAP);
    assign w_append = (r_state == S_FIN) && (r_cur_cnt < CW'(MAX_TRACKS));

    // The chain: each cell hands its previous-frame track to its neighbour,
    // the head of the chain feeding the tail, so one full rotation restores it.
    for (genvar k = 0; k < MAX_TRACKS; k++) begin : g_cell
        gntf_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_copy  (w_copy),
            .i_wr    (w_append && (r_cur_cnt == CW'(k))),
            .i_shin  (w_prev[(k + 1) % MAX_TRACKS]),
            .i_wdata (w_wdata),
            .o_prev  (w_prev[k])
        );
    end

    always_comb begin
        w_dx  = 17'(w_prev[0].cx) - 17'(r_req.center_x);
        w_dy  = 17'(w_prev[0].cy) - 17'(r_req.center_y);
        w_sqx = w_dx * w_dx;
        w_sqy = w_dy * w_dy;
        w_d2  = {1'b0, r_sqx} + {1'b0, r_sqy};
        w_dot = 33'(r_px) + 33'(r_py);
        w_flip = r_matched && w_dot[32];
        w_hx  = w_flip ? neg_sat(r_req.heading_x) : r_req.heading_x;
        w_hy  = w_flip ? neg_sat(r_req.heading_y) : r_req.heading_y;
        w_wdata = '{cx: r_req.center_x, cy: r_req.center_y, hx: w_hx, hy: w_hy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_gate     <= GATE_RESET;
            r_prev_cnt <= '0;
            r_cur_cnt  <= '0;
            r_j        <= '0;
            r_a_v      <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_gate <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    r_a_v <= 1'b0;
                    if (w_accept) begin
                        case (i_req.func)
                            FUNC_BOX: begin
                                r_state <= S_SCAN;
                                r_j     <= '0;
                            end
                            FUNC_SWAP: begin
                                r_prev_cnt <= r_cur_cnt;
                                r_cur_cnt  <= '0;
                            end
                            FUNC_CLEAR: begin
                                r_prev_cnt <= '0;
                                r_cur_cnt  <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_a_v <= (r_j < r_prev_cnt);
                    r_j   <= r_j + CW'(1);
                    if (r_j == CW'(MAX_TRACKS - 1)) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_a_v   <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                    if (w_append) begin
                        r_cur_cnt <= r_cur_cnt + CW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers carry no reset; the match flag is seeded on accept.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req     <= i_req;
            r_matched <= 1'b0;
            r_best    <= '0;
            r_best_d2 <= {1'b0, r_gate};
        end else if (r_a_v && (w_d2 <= r_best_d2)) begin
            // Inclusive gate; a later index on an equal distance wins.
            r_matched <= 1'b1;
            r_best    <= r_a_idx;
            r_best_d2 <= w_d2;
            r_bhx     <= r_a_hx;
            r_bhy     <= r_a_hy;
        end
        r_a_idx <= r_j[IW-1:0];
        r_sqx   <= w_sqx[31:0];
        r_sqy   <= w_sqy[31:0];
        r_a_hx  <= w_prev[0].hx;
        r_a_hy  <= w_prev[0].hy;
        r_px    <= r_bhx * r_req.heading_x;
        r_py    <= r_bhy * r_req.heading_y;
        if (r_state == S_FIN) begin
            r_res.matched       <= r_matched;
            r_res.match_index   <= r_matched ? 6'(r_best) : 6'd0;
            r_res.flipped       <= w_flip;
            r_res.out_heading_x <= w_hx;
            r_res.out_heading_y <= w_hy;
            r_res.overflow      <= !w_append;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // A result only ever follows the final step of a box request.
    a_strobe_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_FIN))
        else $error("result strobe without a finished box");

    // The list counts never pass the chain length.
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev_cnt <= CW'(MAX_TRACKS)) && (r_cur_cnt <= CW'(MAX_TRACKS)))
        else $error("track count beyond chain length");

    // An overflow is reported only while the current list is full.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.overflow) |-> (r_cur_cnt == CW'(MAX_TRACKS)))
        else $error("overflow with room in the current list");

    // An accepted box request makes the unit busy on the next cycle.
    a_box_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.func == FUNC_BOX)) |=> busy)
        else $error("box request did not start a scan");

endmodule

// ===== test/gated_nearest_track_heading_fix_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_nearest_track_heading_fix_unit_tb: self-checking bench for the unit
// Drives box, swap, clear and unused requests with random gaps, tracks both
// lists in a behavioural copy and checks every result strobe field by field.
// ----------------------------------------------------------------------------
module gated_nearest_track_heading_fix_unit_tb;

    import gntf_pkg::*;

    localparam int          N_TRACKS    = 64;
    localparam int          BOX_LATENCY = N_TRACKS + 3;
    localparam int          N_RANDOM    = 1550;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_strobe;
    t_res        o_res;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    gated_nearest_track_heading_fix_unit #(.MAX_TRACKS(N_TRACKS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Behavioural copy of the track lists. Bank bank_sel holds the list being
    // built in this frame; the other bank holds the previous frame's tracks.
    t_track      track_mem [2][N_TRACKS];
    int unsigned prev_count;
    int unsigned cur_count;
    bit          bank_sel;
    logic [31:0] gate_sq;

    t_res        pending_results[$];
    int unsigned n_errors;
    bit          run_ended;

    function automatic logic signed [15:0] negate_sat(logic signed [15:0] v);
        return (v == -16'sd32768) ? 16'sd32767 : -v;
    endfunction

    // Works out the outcome of one request and updates the track lists.
    function automatic void associate_box(t_req r);
        t_res        res;
        longint      dx, dy, dot;
        logic [33:0] d2, best_d2;
        int          best;
        t_track      nearest;
        res = '0;
        best = 0;
        best_d2 = {2'b00, gate_sq};
        case (r.func)
            FUNC_SWAP: begin
                bank_sel   = ~bank_sel;
                prev_count = cur_count;
                cur_count  = 0;
                return;
            end
            FUNC_CLEAR: begin
                prev_count = 0;
                cur_count  = 0;
                return;
            end
            FUNC_BOX: ;
            default: return;
        endcase
        for (int j = 0; j < prev_count; j++) begin
            dx = longint'(track_mem[~bank_sel][j].cx) - longint'(r.center_x);
            dy = longint'(track_mem[~bank_sel][j].cy) - longint'(r.center_y);
            d2 = 34'(dx * dx + dy * dy);
            // Inclusive gate; a later index at equal distance takes over.
            if (d2 <= best_d2) begin
                best_d2     = d2;
                best        = j;
                res.matched = 1'b1;
            end
        end
        res.out_heading_x = r.heading_x;
        res.out_heading_y = r.heading_y;
        if (res.matched) begin
            res.match_index = 6'(best);
            nearest = track_mem[~bank_sel][best];
            dot = longint'(nearest.hx) * longint'(r.heading_x)
                + longint'(nearest.hy) * longint'(r.heading_y);
            if (dot < 0) begin
                res.flipped       = 1'b1;
                res.out_heading_x = negate_sat(r.heading_x);
                res.out_heading_y = negate_sat(r.heading_y);
            end
        end
        if (cur_count >= N_TRACKS) begin
            res.overflow = 1'b1;
        end else begin
            track_mem[bank_sel][cur_count] = '{cx: r.center_x, cy: r.center_y,
                hx: res.out_heading_x, hy: res.out_heading_y};
            cur_count++;
        end
        pending_results = {pending_results, res};
    endfunction

    // Result checker: every strobe is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_res exp_res;
        if (o_strobe && i_rst_n) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result %p", o_res);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_res !== exp_res) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected %p, got %p", exp_res, o_res);
                end
            end
        end
    end

    // Stimulus rows with an optional typed-in result (check_row set).
    typedef struct {
        t_req req;
        bit   check_row;
        t_res res;
    } t_row;

    t_row        directed_rows[$];
    bit          quiet_tail;

    function automatic t_req make_req(logic [1:0] f, int cx, int cy, int hx, int hy);
        t_req r;
        r.func      = f;
        r.center_x  = 16'(cx);
        r.center_y  = 16'(cy);
        r.heading_x = 16'(hx);
        r.heading_y = 16'(hy);
        return r;
    endfunction

    function automatic t_res make_res(bit m, int idx, bit fl, int hx, int hy, bit ov);
        t_res r;
        r.matched       = m;
        r.match_index   = 6'(idx);
        r.flipped       = fl;
        r.out_heading_x = 16'(hx);
        r.out_heading_y = 16'(hy);
        r.overflow      = ov;
        return r;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(t_req rq, bit chk, t_res rs);
        t_row new_row;
        new_row.req       = rq;
        new_row.check_row = chk;
        new_row.res       = rs;
        directed_rows = {directed_rows, new_row};
    endfunction

    // Sends one request; the expected outcome is worked out when it is accepted.
    // Start stays high on return, so the caller drops it before any pause.
    task automatic send_request(t_req r);
        int gap;
        @(negedge i_clk);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        associate_box(r);
    endtask

    // Waits until the unit is idle, then writes the gate.
    task automatic write_gate(logic [31:0] value);
        int guard;
        guard = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (BOX_LATENCY + 4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gate_sq = value;
    endtask

    // Random box, near one of the stored centres when near_track is set, so that gates are exercised.
    function automatic t_req random_box(bit near_track);
        t_req   r;
        t_track t;
        int     n;
        r = make_req(FUNC_BOX, 0, 0, 0, 0);
        r.center_x  = 16'($urandom);
        r.center_y  = 16'($urandom);
        r.heading_x = 16'($urandom_range(0, 32768) - 16384);
        r.heading_y = 16'($urandom_range(0, 32768) - 16384);
        if ($urandom_range(0, 19) == 0)
            r.heading_x = -16'sd32768;
        if ($urandom_range(0, 19) == 0)
            r.heading_y = 16'($urandom);
        n = prev_count;
        if (near_track && n > 0) begin
            t = track_mem[~bank_sel][$urandom_range(0, n - 1)];
            r.center_x = t.cx + 16'($urandom_range(0, 400) - 200);
            r.center_y = t.cy + 16'($urandom_range(0, 400) - 200);
        end
        return r;
    endfunction

    task automatic random_phase(int n_items, bit big_frames);
        int frame_len;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            frame_len = big_frames ? $urandom_range(60, 70) : $urandom_range(1, 12);
            for (int k = 0; k < frame_len && sent < n_items; k++) begin
                send_request(random_box($urandom_range(0, 3) != 0));
                sent++;
            end
            case ($urandom_range(0, 19))
                0:       send_request(make_req(FUNC_CLEAR, 0, 0, 0, 0));
                1:       send_request(make_req(FUNC_UNUSED, $urandom, $urandom,
                                               $urandom, $urandom));
                default: send_request(make_req(FUNC_SWAP, 0, 0, 0, 0));
            endcase
            sent++;
        end
    endtask

    initial begin
        t_row row;
        int   guard;
        n_errors   = 0;
        run_ended  = 0;
        quiet_tail = 0;
        prev_count = 0;
        cur_count  = 0;
        bank_sel   = 0;
        gate_sq    = GATE_RESET;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. An empty previous list never matches.
        add_row(make_req(FUNC_BOX, 0, 0, 16384, 0), 1,
                make_res(0, 0, 0, 16384, 0, 0));
        add_row(make_req(FUNC_BOX, -32768, 32767, -16384, 16384), 1,
                make_res(0, 0, 0, -16384, 16384, 0));
        add_row(make_req(FUNC_BOX, 32767, -32768, 0, -16384), 1,
                make_res(0, 0, 0, 0, -16384, 0));
        add_row(make_req(FUNC_SWAP, 0, 0, 0, 0), 0, '0);
        // Exact hit on the first track with opposite heading: flipped.
        add_row(make_req(FUNC_BOX, 0, 0, -16384, 0), 1,
                make_res(1, 0, 1, 16384, 0, 0));
        // Two equal distances: the later index wins; most negative saturates.
        add_row(make_req(FUNC_BOX, 0, 0, -32768, 0), 0, '0);
        add_row(make_req(FUNC_SWAP, 0, 0, 0, 0), 0, '0);
        add_row(make_req(FUNC_BOX, 0, 0, 100, 5), 0, '0);
        // Far box: unmatched, heading passes through.
        add_row(make_req(FUNC_BOX, 20000, 20000, 1, -1), 1,
                make_res(0, 0, 0, 1, -1, 0));
        add_row(make_req(FUNC_UNUSED, -1, -1, -1, -1), 0, '0);
        add_row(make_req(FUNC_CLEAR, 0, 0, 0, 0), 0, '0);
        add_row(make_req(FUNC_BOX, 0, 0, 16384, 16384), 1,
                make_res(0, 0, 0, 16384, 16384, 0));
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.req);
            if (row.check_row && pending_results.size() != 0
                && pending_results[$] !== row.res) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("directed row %0d: expected %p, predicted %p",
                             i, row.res, pending_results[$]);
            end
        end

        // Gate at the bottom: only exact hits match, incl. edge of gate at 1.
        write_gate(32'd0);
        send_request(make_req(FUNC_CLEAR, 0, 0, 0, 0));
        send_request(make_req(FUNC_BOX, 10, 10, 16384, 0));
        send_request(make_req(FUNC_SWAP, 0, 0, 0, 0));
        send_request(make_req(FUNC_BOX, 10, 10, -3, 0));
        send_request(make_req(FUNC_BOX, 11, 10, -3, 0));
        write_gate(32'd1);
        send_request(make_req(FUNC_BOX, 11, 10, -3, 0));
        random_phase(250, 0);

        // Full list: overflow, and indices up to 63 in the next frame.
        write_gate(32'hFFFF_FFFF);
        send_request(make_req(FUNC_CLEAR, 0, 0, 0, 0));
        random_phase(140, 1);

        write_gate(32'd41943);
        random_phase(500, 0);
        write_gate($urandom);
        random_phase(300, 0);
        write_gate(32'd2_000_000);
        quiet_tail = 1;
        random_phase(N_RANDOM - 1190, 0);

        @(negedge i_clk);
        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (BOX_LATENCY + 4) @(negedge i_clk);
        run_ended = 1;
        if (n_errors == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Upper bound well above the slowest correct run.
    initial begin
        #2_000_000;
        if (!run_ended)
            $display("FAILURE");
        $finish;
    end

endmodule
